// File: design/aqz_pkg.sv
// Shared types and constants of the absmax int8 quantizer.
package aqz_pkg;

   // Float32 encodings.
   localparam logic [31:0] ONE_BITS     = 32'h3F80_0000;
   localparam logic [31:0] INF_BITS     = 32'h7F80_0000;
   localparam logic [7:0]  EXP_ALL_ONES = 8'hFF;

   // The dividend 127.0 is 1.984375 * 2^6.
   localparam logic [23:0]        DIVIDEND_MANT = 24'hFE_0000;
   localparam logic signed [10:0] DIVIDEND_EXP  = 11'sd6;
   localparam logic signed [10:0] EXP_BIAS      = 11'sd127;
   localparam logic signed [10:0] SUBNORM_EXP   = -11'sd126;
   localparam logic signed [10:0] BIASED_INF    = 11'sd255;

   // Quotient bits produced by the divider, one per cycle.
   localparam logic [4:0] DIV_LAST = 5'd25;

   // Input operation codes.
   localparam logic OP_SCAN     = 1'b0;
   localparam logic OP_QUANTIZE = 1'b1;

   // Saturation limits of the int8 result.
   localparam logic [7:0] Q_MAX = 8'h7F;
   localparam logic [7:0] Q_MIN = 8'h80;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_NORM_MAX = 8'b0000_0010,
      ST_DIV      = 8'b0000_0100,
      ST_DIV_FIN  = 8'b0000_1000,
      ST_VAL_LOAD = 8'b0001_0000,
      ST_NORM_VAL = 8'b0010_0000,
      ST_MUL      = 8'b0100_0000,
      ST_OUT      = 8'b1000_0000
   } aqz_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic norm_load_max;
      logic norm_load_val;
      logic norm_shift;
      logic div_init;
      logic div_step;
      logic div_write;
      logic mul_load;
      logic out_load;
   } aqz_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_div;
      logic norm_done;
      logic div_last;
      logic val_skip;
      logic out_free;
   } aqz_status_type;

endpackage

// File: design/absmax_int8_quantizer.sv
// Scan items (op 0) update the running maximum magnitude with no result and never stall
// the input. A quantize item (op 1) holds the input while it is worked on, and its result
// is offered in the cycle in which the next item can be taken. A subnormal value is first
// shifted by the one-bit-a-cycle normalizer; zero, NaN, infinity and an infinite scale skip
// the normalizer and the multiplier. The first quantize item of a tensor additionally forms
// the scale 127/max: the maximum is normalized, a restoring divider produces the quotient
// bits and the scale is written. The finished result sits in an output register, so the
// block waits only when that register is still full.
module absmax_int8_quantizer import aqz_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_op,
   input  logic [31:0]       req_value,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [7:0] rsp_quantized,
   output logic              rsp_is_last
);

   aqz_cmd_type    cmd;
   aqz_status_type status;

   aqz_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   aqz_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_op        (req_op),
      .req_value     (req_value),
      .req_last      (req_last),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_quantized (rsp_quantized),
      .rsp_is_last   (rsp_is_last)
   );

endmodule

// File: design/aqz_datapath.sv
// Datapath: maximum tracking, scale divider, normalizer, multiplier and rounding.
module aqz_datapath import aqz_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  aqz_cmd_type       cmd,
   output aqz_status_type    status,
   input  logic              req_op,
   input  logic [31:0]       req_value,
   input  logic              req_last,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic signed [7:0] rsp_quantized,
   output logic              rsp_is_last
);

   logic [30:0]        max_ff, max_in;
   logic [31:0]        scale_ff, scale_in;
   logic               ready_ff, ready_in;
   logic [31:0]        val_ff, val_in;
   logic               last_ff, last_in;
   logic [23:0]        nm_ff, nm_in;
   logic signed [10:0] ne_ff, ne_in;
   logic [24:0]        rem_ff, rem_in;
   logic [25:0]        quo_ff, quo_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [47:0]        prod_ff, prod_in;
   logic signed [10:0] pe_ff, pe_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_q_ff, rsp_q_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               val_finite, val_zero, scale_inf, force_zero;
   logic [30:0]        norm_src;
   logic               div_ge;
   logic [24:0]        div_diff;
   logic [23:0]        dm;
   logic               drb, dsb, dinc;
   logic [24:0]        dsum;
   logic signed [10:0] dexp, dbiased;
   logic               phi, prb, psb, pinc;
   logic [23:0]        pm, pmant;
   logic [24:0]        psum;
   logic signed [10:0] pexp;
   logic [4:0]         sh;
   logic [23:0]        int_part;
   logic               half_bit;
   logic [7:0]         rounded;
   logic [7:0]         q_val;

   // Flags of the held quantize value and scale.
   assign val_finite = val_ff[30:23] != EXP_ALL_ONES;
   assign val_zero   = val_ff[30:0] == 31'd0;
   assign scale_inf  = scale_ff[30:23] == EXP_ALL_ONES;
   assign force_zero = !val_finite || val_zero;

   assign status.need_div  = !ready_ff && (max_ff != 31'd0);
   assign status.norm_done = nm_ff[23];
   assign status.div_last  = cnt_ff == DIV_LAST;
   assign status.val_skip  = force_zero || scale_inf;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   // One restoring division step.
   assign div_ge   = rem_ff >= {1'b0, nm_ff};
   assign div_diff = rem_ff - {1'b0, nm_ff};

   // Final rounding of the quotient to float32.
   always_comb begin
      if (quo_ff[25]) begin
         dm   = quo_ff[25:2];
         drb  = quo_ff[1];
         dsb  = quo_ff[0] | (|rem_ff);
         dexp = DIVIDEND_EXP - ne_ff;
      end else begin
         dm   = quo_ff[24:1];
         drb  = quo_ff[0];
         dsb  = |rem_ff;
         dexp = DIVIDEND_EXP - ne_ff - 11'sd1;
      end
      dinc    = drb & (dsb | dm[0]);
      dsum    = {1'b0, dm} + {24'd0, dinc};
      dbiased = dexp + EXP_BIAS + $signed({10'd0, dsum[24]});
   end

   // Round the product to float32, then to an integer half away from zero.
   always_comb begin
      phi = prod_ff[47];
      if (phi) begin
         pm  = prod_ff[47:24];
         prb = prod_ff[23];
         psb = |prod_ff[22:0];
      end else begin
         pm  = prod_ff[46:23];
         prb = prod_ff[22];
         psb = |prod_ff[21:0];
      end
      pinc     = prb & (psb | pm[0]);
      psum     = {1'b0, pm} + {24'd0, pinc};
      pmant    = psum[24] ? 24'h80_0000 : psum[23:0];
      pexp     = pe_ff + $signed({10'd0, phi}) + $signed({10'd0, psum[24]});
      sh       = 5'(11'sd23 - pexp);
      int_part = pmant >> sh;
      half_bit = pmant[5'(sh - 5'd1)];
      rounded  = int_part[7:0] + {7'd0, half_bit};
      if (force_zero) begin
         q_val = 8'd0;
      end else if (scale_inf || pexp >= 11'sd7) begin
         q_val = val_ff[31] ? Q_MIN : Q_MAX;
      end else if (pexp < -11'sd1) begin
         q_val = 8'd0;
      end else if (val_ff[31]) begin
         q_val = 8'd0 - rounded;
      end else begin
         q_val = (rounded > Q_MAX) ? Q_MAX : rounded;
      end
   end

   // Next values of all registers.
   always_comb begin
      max_in       = max_ff;
      scale_in     = scale_ff;
      ready_in     = ready_ff;
      val_in       = val_ff;
      last_in      = last_ff;
      nm_in        = nm_ff;
      ne_in        = ne_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      pe_in        = pe_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_q_in     = rsp_q_ff;
      rsp_last_in  = rsp_last_ff;
      norm_src     = cmd.norm_load_max ? max_ff : val_ff[30:0];

      // Input transfer: scan items update the maximum right away.
      if (cmd.accept) begin
         val_in  = req_value;
         last_in = req_last;
         if (req_op == OP_SCAN) begin
            if (req_value[30:23] != EXP_ALL_ONES && req_value[30:0] > max_ff) begin
               max_in = req_value[30:0];
            end
         end else if (!ready_ff && max_ff == 31'd0) begin
            ready_in = 1'b1;
         end
      end

      // Normalizer load and one-bit shift.
      if (cmd.norm_load_max || cmd.norm_load_val) begin
         if (norm_src[30:23] == 8'd0) begin
            nm_in = {1'b0, norm_src[22:0]};
            ne_in = SUBNORM_EXP;
         end else begin
            nm_in = {1'b1, norm_src[22:0]};
            ne_in = $signed({3'd0, norm_src[30:23]}) - EXP_BIAS;
         end
      end else if (cmd.norm_shift) begin
         nm_in = {nm_ff[22:0], 1'b0};
         ne_in = ne_ff - 11'sd1;
      end

      // Divider.
      if (cmd.div_init) begin
         rem_in = {1'b0, DIVIDEND_MANT};
         quo_in = 26'd0;
         cnt_in = 5'd0;
      end else if (cmd.div_step) begin
         rem_in = {(div_ge ? div_diff[23:0] : rem_ff[23:0]), 1'b0};
         quo_in = {quo_ff[24:0], div_ge};
         cnt_in = cnt_ff + 5'd1;
      end
      if (cmd.div_write) begin
         ready_in = 1'b1;
         if (dbiased >= BIASED_INF) begin
            scale_in = INF_BITS;
         end else begin
            scale_in = {1'b0, dbiased[7:0], dsum[22:0]};
         end
      end

      // Mantissa product and exponent sum.
      if (cmd.mul_load) begin
         prod_in = nm_ff * {1'b1, scale_ff[22:0]};
         pe_in   = ne_ff + ($signed({3'd0, scale_ff[30:23]}) - EXP_BIAS);
      end

      // Result transfer; the last item starts a fresh tensor.
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_q_in     = q_val;
         rsp_last_in  = last_ff;
         if (last_ff) begin
            max_in   = 31'd0;
            scale_in = ONE_BITS;
            ready_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff       <= 31'd0;
         scale_ff     <= ONE_BITS;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_ff       <= max_in;
         scale_ff     <= scale_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      val_ff      <= val_in;
      last_ff     <= last_in;
      nm_ff       <= nm_in;
      ne_ff       <= ne_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      prod_ff     <= prod_in;
      pe_ff       <= pe_in;
      rsp_q_ff    <= rsp_q_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_quantized = $signed(rsp_q_ff);
   assign rsp_is_last   = rsp_last_ff;

endmodule

// File: design/aqz_controller.sv
// Controller state machine that sequences one item through the datapath.
module aqz_controller import aqz_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_op,
   output logic           req_stall,
   input  aqz_status_type status,
   output aqz_cmd_type    cmd
);

   aqz_state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_op == OP_QUANTIZE) begin
                  if (status.need_div) begin
                     cmd.norm_load_max = 1'b1;
                     state_in          = ST_NORM_MAX;
                  end else begin
                     state_in = ST_VAL_LOAD;
                  end
               end
            end
         end
         ST_NORM_MAX: begin
            if (status.norm_done) begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end else begin
               cmd.norm_shift = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DIV_FIN;
            end
         end
         ST_DIV_FIN: begin
            cmd.div_write = 1'b1;
            state_in      = ST_VAL_LOAD;
         end
         ST_VAL_LOAD: begin
            // Zero, non-finite values and an infinite scale need no product.
            if (status.val_skip) begin
               state_in = ST_OUT;
            end else begin
               cmd.norm_load_val = 1'b1;
               state_in          = ST_NORM_VAL;
            end
         end
         ST_NORM_VAL: begin
            if (status.norm_done) begin
               state_in = ST_MUL;
            end else begin
               cmd.norm_shift = 1'b1;
            end
         end
         ST_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/aqz_checker.sv
// Port-level checks of the quantizer and their binding to the top level.
module aqz_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_op,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_quantized,
   input logic       rsp_is_last
);

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_quantized) && $stable(rsp_is_last))
      else $error("stalled result changed");

   // A scan transfer never blocks the next item.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_op |=> !req_stall)
      else $error("scan transfer stalled the input");

   // A quantize transfer keeps the input busy while it is worked on.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_op |=> req_stall)
      else $error("input taken during quantize work");

   // A new result appears only after a quantize transfer has left the input stalled.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without quantize work");

endmodule

bind absmax_int8_quantizer aqz_checker u_aqz_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_op        (req_op),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_quantized (rsp_quantized),
   .rsp_is_last   (rsp_is_last)
);
